@@ rtl/bfdh_pkg.sv @@
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants of the double-hash Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdh_pkg;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_MULT   = 64'h00000100000001b3;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_ADD   = 1'b1
  } op_e;

  typedef enum logic {
    REG_NUM_HASHES  = 1'b0,
    REG_FILTER_SIZE = 1'b1
  } reg_e;

  typedef struct packed {
    logic        operation;
    logic [63:0] key;
  } in_word_t;

  typedef struct packed {
    logic        present;
    logic [4:0]  newly_set;
    logic [16:0] total_set;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture key and start hashing
    logic hash_step; // one hash step
    logic pos_start; // start the position for the current probe
    logic pos_step;  // one step of the modulo unit
    logic wr;        // write the current word back with the bit set
    logic next;      // advance to the next probe
    logic clr;       // clear one store word
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hash_done;
    logic pos_done;
    logic bit_set;
    logic last_probe;
    logic no_probe;
    logic clr_done;
  } stat_t;

  // Mixer hash, one line at a time.
  function automatic logic [63:0] mix_step(input logic [63:0] v, input logic [2:0] s);
    logic [63:0] r;
    begin
      r = v;
      unique case (s)
        3'd0: r = (~v) + (v << 21);
        3'd1: r = v ^ (v >> 24);
        3'd2: r = (v + (v << 3)) + (v << 8);
        3'd3: r = v ^ (v >> 14);
        3'd4: r = (v + (v << 2)) + (v << 4);
        3'd5: r = v ^ (v >> 28);
        3'd6: r = v + (v << 31);
        default: r = v;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/bfdh_ram.sv @@
// ----------------------------------------------------------------------------
// bfdh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

@@ rtl/bfdh_datapath.sv @@
// ----------------------------------------------------------------------------
// bfdh_datapath
// Hash units, probe position arithmetic, bit store and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_datapath
  import bfdh_pkg::*;
#(
  parameter int FilterBits = 65536,
  parameter int MaxHashes  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire in_word_t    in_i,
  input  wire logic [4:0]  num_hashes_i,
  input  wire logic [16:0] filter_size_i,
  output stat_t            stat_o,
  output out_word_t        res_o
);

  localparam int Words = (FilterBits + 63) / 64;
  localparam int AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int PosW  = $clog2(FilterBits) + 1;
  localparam int CntW  = $clog2(MaxHashes + 1);
  localparam int SetW  = PosW;

  // Hash state.
  logic [63:0] key_q, h1_q, h2_q;
  logic [3:0]  hcnt_q;

  // Probe position: pos = (h1 + i*h2) mod size, maintained as sum_q = h1 + i*h2
  // and reduced by bit-serial restoring division.
  logic [63:0]   sum_q, dvd_q;
  logic [PosW:0] rem_q;
  logic [6:0]    dcnt_q;
  logic [PosW-1:0] size;
  logic [CntW-1:0] probes, pcnt_q;

  logic [SetW-1:0] total_q;
  logic [4:0]      fresh_q;
  logic            all_q;
  logic [AddrW:0]  ccnt_q;

  logic [63:0]     rdata, wdata;
  logic [AddrW-1:0] addr;
  logic            we;
  logic [PosW-1:0] pos;
  logic [PosW:0]   trial;

  always_comb begin
    if (filter_size_i < 17'd64) begin
      size = PosW'(64);
    end else if (32'(filter_size_i) > FilterBits) begin
      size = PosW'(FilterBits);
    end else begin
      size = PosW'(filter_size_i);
    end
    if (32'(num_hashes_i) > MaxHashes) begin
      probes = CntW'(MaxHashes);
    end else begin
      probes = CntW'(num_hashes_i);
    end
  end

  assign pos   = rem_q[PosW-1:0];
  assign trial = {rem_q[PosW-1:0], dvd_q[63]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= in_i.key;
      h1_q   <= in_i.key;
      h2_q   <= FNV_OFFSET;
      hcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      if (hcnt_q < 4'd7) begin
        h1_q <= mix_step(h1_q, hcnt_q[2:0]);
      end
      h2_q   <= ((h2_q << 40) + (h2_q << 8) + (h2_q << 7) + (h2_q << 5) +
                 (h2_q << 4) + (h2_q << 1) + h2_q) ^ {56'd0, key_q[8*hcnt_q[2:0] +: 8]};
      hcnt_q <= hcnt_q + 4'd1;
    end
    if (cmd_i.pos_start) begin
      dvd_q  <= (pcnt_q == '0) ? h1_q : sum_q;
      if (pcnt_q == '0) begin
        sum_q <= h1_q;
      end
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.pos_step) begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= (trial >= {1'b0, size}) ? trial - {1'b0, size} : trial;
      dcnt_q <= dcnt_q + 7'd1;
    end
    if (cmd_i.next) begin
      sum_q <= sum_q + h2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      fresh_q <= '0;
      all_q   <= 1'b1;
      pcnt_q  <= '0;
      ccnt_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        fresh_q <= '0;
        all_q   <= 1'b1;
        pcnt_q  <= '0;
      end
      if (cmd_i.wr) begin
        fresh_q <= fresh_q + 5'd1;
        total_q <= total_q + SetW'(1);
        all_q   <= 1'b0;
      end
      if (cmd_i.next) begin
        pcnt_q <= pcnt_q + CntW'(1);
        if (!stat_o.bit_set) begin
          all_q <= 1'b0;
        end
      end
      if (cmd_i.clr && ccnt_q != (AddrW+1)'(Words)) begin
        ccnt_q <= ccnt_q + (AddrW+1)'(1);
      end
    end
  end

  assign addr  = cmd_i.clr ? ccnt_q[AddrW-1:0] : AddrW'(pos >> 6);
  assign we    = cmd_i.wr || cmd_i.clr;
  assign wdata = cmd_i.clr ? 64'd0 : (rdata | (64'd1 << pos[5:0]));

  bfdh_ram #(.Width(64), .Depth(Words)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    stat_o.hash_done  = (hcnt_q == 4'd8);
    stat_o.pos_done   = (dcnt_q == 7'd64);
    stat_o.bit_set    = rdata[pos[5:0]];
    stat_o.last_probe = (pcnt_q + CntW'(1) == probes);
    stat_o.no_probe   = (probes == '0);
    stat_o.clr_done   = (ccnt_q == (AddrW+1)'(Words));
    res_o.present     = all_q;
    res_o.newly_set   = fresh_q;
    res_o.total_set   = 17'(total_q);
  end

endmodule

`default_nettype wire

@@ rtl/bfdh_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfdh_ctrl
// Sequencer for clearing, hashing, probing and reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_ctrl
  import bfdh_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic  add_i,
  input  wire stat_t stat_i,
  output logic       busy_o,
  output logic       done_o,
  output cmd_t       cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_PSTRT = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_READ  = 9'b000100000,
    S_TEST  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   add_q, done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i && !done_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) begin
          state_d = stat_i.no_probe ? S_DONE : S_PSTRT;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_PSTRT: begin
        cmd_o.pos_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.pos_done) begin
          state_d = S_READ;
        end else begin
          cmd_o.pos_step = 1'b1;
        end
      end
      S_READ: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if (!stat_i.bit_set && add_q) begin
          cmd_o.wr = 1'b1;
          state_d  = S_WRITE;
        end else begin
          cmd_o.next = 1'b1;
          if (!stat_i.bit_set || stat_i.last_probe) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PSTRT;
          end
        end
      end
      S_WRITE: begin
        // Word already written; the read of the same address returns the new word.
        state_d = S_TEST;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      add_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_DONE);
      if (cmd_o.load) begin
        add_q <= add_i;
      end
    end
  end

  assign busy_o = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ rtl/bloom_filter_double_hash_top.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_double_hash_top
// Bloom filter over 64-bit keys with double hashing.
// ----------------------------------------------------------------------------
// A command word (operation, key) is taken when start is high and busy is
// low. Each word gives one result word on res_o, valid for the one cycle in
// which done_o is high; the receiver cannot stall it.
// Hashing takes eight steps, each folding one key byte into the FNV hash; the
// first seven also apply one mixer line. Each probe then passes through a
// start, the bit-serial modulo unit, a store read and a test. An add that
// sets a clear bit adds a write and a retest. The next word can be taken in
// the cycle after done_o is high.
// Configuration writes go through cfg_valid_i/cfg_ready_o with cfg_index_i
// and cfg_data_i, and are always accepted; they are meant for idle time only.
// After reset the block clears the bit store, one word per cycle, and keeps
// busy high until done.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_double_hash_top
  import bfdh_pkg::*;
#(
  parameter int FILTER_BITS = 65536,
  parameter int MAX_HASHES  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire in_word_t    cmd_i,
  output logic             done_o,
  output out_word_t        res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);

  logic [4:0]  num_hashes_q;
  logic [16:0] filter_size_q;
  cmd_t        cmd;
  stat_t       stat;
  reg_e        cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_hashes_q  <= 5'd3;
      filter_size_q <= 17'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg)
        REG_NUM_HASHES:  num_hashes_q  <= cfg_data_i[4:0];
        REG_FILTER_SIZE: filter_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bfdh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .add_i  (cmd_i.operation),
    .stat_i (stat),
    .busy_o (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  bfdh_datapath #(.FilterBits(FILTER_BITS), .MaxHashes(MAX_HASHES)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_i         (cmd_i),
    .num_hashes_i (num_hashes_q),
    .filter_size_i(filter_size_q),
    .stat_o       (stat),
    .res_o        (res_o)
  );

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result without a word in flight");
  a_no_double_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");
  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word not taken");

endmodule

`default_nettype wire
